### src/okf_pkg.sv
// package for the opposing key filter: payload types, pair register layout, constants
package okf_pkg;

    localparam int REG_COUNT         = 4;
    localparam int REG_IDX_W         = $clog2(REG_COUNT);
    localparam int CFG_INDEX_W       = 8;
    localparam int CODE_W            = 16;
    localparam int STATE_W           = 16;
    localparam int INFO_W            = 32;
    localparam int PAIR_W            = 2 * CODE_W + 1;
    localparam int PAIR_EXT_BIT      = 2 * CODE_W;
    localparam int UP_BIT            = 0;
    localparam int EXT_BIT           = 1;
    localparam int FIFO_DEPTH        = 4;
    localparam int FIFO_PTR_W        = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W        = $clog2(FIFO_DEPTH + 1);
    localparam int NUM_PAIRS_DEFAULT = 4;

    typedef logic [PAIR_W-1:0] okf_pair_t;
    typedef okf_pair_t [REG_COUNT-1:0] okf_pair_arr_t;

    // a/d, w/s, left/right (extended), up/down (extended)
    localparam okf_pair_arr_t PAIR_RESET = {
        33'h1_0050_0048,
        33'h1_004D_004B,
        33'h0_001F_0011,
        33'h0_0020_001E
    };

    typedef struct packed {
        logic [CODE_W-1:0]  key_code;
        logic [STATE_W-1:0] key_state;
        logic [INFO_W-1:0]  key_info;
    } okf_in_t;

    typedef struct packed {
        logic [CODE_W-1:0]  out_code;
        logic [STATE_W-1:0] out_state;
        logic [INFO_W-1:0]  out_info;
        logic               out_last;
    } okf_out_t;

    typedef struct packed {
        logic [1:0] count;
        okf_out_t   first;
        okf_out_t   second;
    } okf_push_t;

endpackage

### src/opposing_key_last_wins_filter.sv
// top level of the opposing key filter with last input priority
//
//  channel  signals                         direction  payload
//  key      key_valid / key_ready           in         okf_in_t key_item
//  res      res_valid / res_ready           out        okf_out_t res_item
//  cfg      cfg_valid / cfg_ready           in         cfg_index, cfg_data
//
//  a stroke is registered, decided combinationally and its zero, one or two results queued
//  one stroke per cycle enters while the queue has room; the result queue drains one
//  transaction per cycle while res_ready is high, so a run of strokes with two results fills it
//  a stroke waits in the input register until the queue has room, then its results are queued
//  reset restores the default pairs and clears all held flags
//  res_ready low lets the queue reach three or four entries, then key_ready drops once a stroke waits
module opposing_key_last_wins_filter #(
    parameter int NUM_PAIRS = okf_pkg::NUM_PAIRS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            key_valid,
    output logic                            key_ready,
    input  okf_pkg::okf_in_t                key_item,
    output logic                            res_valid,
    input  logic                            res_ready,
    output okf_pkg::okf_out_t               res_item,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [okf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [okf_pkg::PAIR_W-1:0]      cfg_data
);
    import okf_pkg::*;

    logic          key_valid_reg;
    logic          key_valid_next;
    okf_in_t       key_item_reg;
    logic          accept;
    logic          fire;
    logic          room;
    okf_pair_arr_t pairs;
    okf_push_t     push;

    assign cfg_ready      = 1'b1;
    assign fire           = key_valid_reg && room;
    assign key_ready      = !key_valid_reg || fire;
    assign accept         = key_valid && key_ready;
    assign key_valid_next = accept || (key_valid_reg && !fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_valid_reg <= 1'b0;
        end
        else
        begin
            key_valid_reg <= key_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_item_reg <= key_item;
        end
    end

    okf_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pairs     (pairs)
    );

    okf_decide #(
        .NUM_PAIRS (NUM_PAIRS)
    ) u_decide (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (key_item_reg),
        .pairs (pairs),
        .push  (push)
    );

    okf_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

endmodule

### src/okf_cfg_regs.sv
// pair configuration registers
module okf_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic [okf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [okf_pkg::PAIR_W-1:0]       cfg_data,
    output okf_pkg::okf_pair_arr_t           pairs
);
    import okf_pkg::*;

    okf_pair_arr_t pairs_reg;
    logic          wr_en;

    assign wr_en = cfg_valid && (cfg_index < CFG_INDEX_W'(REG_COUNT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pairs_reg <= PAIR_RESET;
        end
        else if (wr_en)
        begin
            pairs_reg[cfg_index[REG_IDX_W-1:0]] <= cfg_data;
        end
    end

    assign pairs = pairs_reg;

endmodule

### src/okf_decide.sv
// pair match, held flags and result generation for one stroke
module okf_decide #(
    parameter int NUM_PAIRS = okf_pkg::NUM_PAIRS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  okf_pkg::okf_in_t       item,
    input  okf_pkg::okf_pair_arr_t pairs,
    output okf_pkg::okf_push_t     push
);
    import okf_pkg::*;

    localparam int HELD_W = 2 * NUM_PAIRS;

    logic [HELD_W-1:0]  held_reg;
    logic [HELD_W-1:0]  held_next;
    logic [HELD_W-1:0]  self_mask;
    logic [HELD_W-1:0]  other_mask;
    logic               hit;
    logic               ext;
    logic               is_down;
    logic               self_held;
    logic               other_held;
    logic [CODE_W-1:0]  other_code;
    logic [STATE_W-1:0] ext_state;
    logic [STATE_W-1:0] up_state;
    okf_out_t           orig;
    okf_out_t           orig_mid;

    // lowest pair wins, code in the low half beats the code in the high half
    always_comb
    begin
        hit        = 1'b0;
        self_mask  = '0;
        other_mask = '0;
        other_code = '0;
        ext        = item.key_state[EXT_BIT];
        is_down    = !item.key_state[UP_BIT];
        for (int p = NUM_PAIRS - 1; p >= 0; p--)
        begin
            if (pairs[p][PAIR_EXT_BIT] == ext)
            begin
                if (pairs[p][2*CODE_W-1:CODE_W] == item.key_code)
                begin
                    hit              = 1'b1;
                    self_mask        = '0;
                    other_mask       = '0;
                    self_mask[2*p+1] = 1'b1;
                    other_mask[2*p]  = 1'b1;
                    other_code       = pairs[p][CODE_W-1:0];
                end
                if (pairs[p][CODE_W-1:0] == item.key_code)
                begin
                    hit               = 1'b1;
                    self_mask         = '0;
                    other_mask        = '0;
                    self_mask[2*p]    = 1'b1;
                    other_mask[2*p+1] = 1'b1;
                    other_code        = pairs[p][2*CODE_W-1:CODE_W];
                end
            end
        end
    end

    assign self_held  = |(held_reg & self_mask);
    assign other_held = |(held_reg & other_mask);

    always_comb
    begin
        ext_state          = '0;
        ext_state[EXT_BIT] = ext;
        up_state           = ext_state;
        up_state[UP_BIT]   = 1'b1;
    end

    assign orig     = '{out_code: item.key_code, out_state: item.key_state,
                        out_info: item.key_info, out_last: 1'b1};
    assign orig_mid = '{out_code: item.key_code, out_state: item.key_state,
                        out_info: item.key_info, out_last: 1'b0};

    always_comb
    begin
        held_next   = held_reg;
        push.count  = 2'd0;
        push.first  = orig;
        push.second = orig;
        if (fire)
        begin
            if (!hit)
            begin
                push.count = 2'd1;
            end
            else if (is_down)
            begin
                if (!self_held)
                begin
                    held_next = held_reg | self_mask;
                    if (other_held)
                    begin
                        // injected release of the opposing key goes first
                        push.count = 2'd2;
                        push.first = '{out_code: other_code, out_state: up_state,
                                       out_info: '0, out_last: 1'b0};
                    end
                    else
                    begin
                        push.count = 2'd1;
                    end
                end
            end
            else
            begin
                held_next = held_reg & ~self_mask;
                if (other_held)
                begin
                    // opposing key still down: press it again
                    push.count  = 2'd2;
                    push.first  = orig_mid;
                    push.second = '{out_code: other_code, out_state: ext_state,
                                    out_info: '0, out_last: 1'b1};
                end
                else
                begin
                    push.count = 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else
        begin
            held_reg <= held_next;
        end
    end

endmodule

### src/okf_out_fifo.sv
// result queue, up to two writes and one read per cycle
module okf_out_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  okf_pkg::okf_push_t push,
    output logic               room,
    output logic               res_valid,
    input  logic               res_ready,
    output okf_pkg::okf_out_t  res_item
);
    import okf_pkg::*;

    okf_out_t                mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   wr_ptr_inc;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   count_reg;
    logic [FIFO_CNT_W-1:0]   count_next;
    logic                    pop;

    assign pop        = res_valid && res_ready;
    assign room       = count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2);
    assign res_valid  = count_reg != '0;
    assign res_item   = mem_reg[rd_ptr_reg];
    assign wr_ptr_inc = wr_ptr_reg + FIFO_PTR_W'(1);

    assign wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push.count);
    assign rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
    assign count_next  = count_reg + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_inc] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue overfilled");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> room)
        else $error("results pushed without room");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && push.count == 2'd0) |=> count_reg == $past(count_reg) - FIFO_CNT_W'(1))
        else $error("queue count wrong after read");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != FIFO_CNT_W'(FIFO_DEPTH) |->
            FIFO_PTR_W'(wr_ptr_reg - rd_ptr_reg) == FIFO_PTR_W'(count_reg))
        else $error("queue pointers disagree with count");

endmodule
